FILE: src/vconv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vconv_pkg: shared constants for the valid-mode 2-D convolution block
// Sizes, field widths, register indexes and opcodes.
// ----------------------------------------------------------------------------
package vconv_pkg;
    localparam int MAX_IMAGE_WIDTH = 256;
    localparam int MAX_KERNEL_SIZE = 8;
    localparam int KSTORE_DEPTH    = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
    localparam int LSTORE_DEPTH    = MAX_KERNEL_SIZE * MAX_IMAGE_WIDTH;
    localparam int COL_W           = $clog2(MAX_IMAGE_WIDTH);
    localparam int RING_W          = $clog2(MAX_KERNEL_SIZE);
    localparam int KIDX_W          = $clog2(KSTORE_DEPTH);
    localparam int LADDR_W         = $clog2(LSTORE_DEPTH);
    localparam int SUM_W           = 40;

    // register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd2;
    localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd3;

    // opcodes
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
endpackage
`default_nettype wire

FILE: src/vconv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vconv_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/valid_2d_convolution_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// valid_2d_convolution_top: valid-mode 2-D cross-correlation
// Kernel and line stores in RAM, one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A coefficient request is taken while the block stays idle. A pixel request
// that completes a window starts a run: the window is read one tap per cycle
// from the line RAM and kernel RAM through a single 16x16 multiplier and a
// 40-bit accumulator, the read and product registers then drain, and the sum
// is loaded into the output register, so the kernel area sets the rate. A
// pixel that completes no window leaves the block idle. The next request is
// taken while a result waits on the output register; a further finished
// window holds the block until that register is free. Configuration is
// accepted only while the block is idle and restarts the plane.
module valid_2d_convolution_top
    import vconv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_opcode,
    input  wire logic signed [15:0] s_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [SUM_W-1:0] m_window_sum,
    output logic                   m_last_of_plane,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [8:0]  iw_reg;
    logic [15:0] ih_reg;
    logic [3:0]  kw_reg, kh_reg;
    logic [15:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [KIDX_W-1:0] kwi_reg;

    logic [RING_W-1:0] r0_reg, ii_reg, jj_reg;
    logic [COL_W-1:0]  c0_reg;
    logic [KIDX_W-1:0] kidx_reg;
    logic              last_reg;
    logic              rd_v_reg, prod_v_reg;
    logic signed [31:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;

    // effective register values
    logic [8:0]  ew;
    logic [15:0] eh;
    logic [3:0]  ekw, ekh;
    always_comb begin
        ew  = (iw_reg == 9'd0) ? 9'd1 : ((iw_reg > 9'(MAX_IMAGE_WIDTH)) ?
              9'(MAX_IMAGE_WIDTH) : iw_reg);
        eh  = (ih_reg == 16'd0) ? 16'd1 : ih_reg;
        ekw = (kw_reg == 4'd0) ? 4'd1 : ((kw_reg > 4'(MAX_KERNEL_SIZE)) ?
              4'(MAX_KERNEL_SIZE) : kw_reg);
        ekh = (kh_reg == 4'd0) ? 4'd1 : ((kh_reg > 4'(MAX_KERNEL_SIZE)) ?
              4'(MAX_KERNEL_SIZE) : kh_reg);
    end

    // handshakes
    logic s_acc, cfg_acc, pix_acc, coef_acc;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign s_acc     = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign pix_acc   = s_acc && (s_opcode == OP_PIXEL);
    assign coef_acc  = s_acc && (s_opcode == OP_COEF);

    // clamped position of the incoming pixel and window decision
    logic [15:0] row_c;
    logic [COL_W-1:0] col_c;
    logic emit;
    logic [15:0] r0_c;
    logic [COL_W-1:0] c0_c;
    always_comb begin
        row_c = (row_reg >= eh) ? eh - 16'd1 : row_reg;
        col_c = ({1'b0, col_reg} >= ew) ? COL_W'(ew - 9'd1) : col_reg;
        emit  = ({5'd0, ekw} <= ew) && ({12'd0, ekh} <= eh) &&
                ({1'b0, row_c} + 17'd1 >= {13'd0, ekh}) &&
                ({1'b0, col_c} + 9'd1 >= {5'd0, ekw});
        r0_c  = row_c + 16'd1 - {12'd0, ekh};
        c0_c  = COL_W'({1'b0, col_c} + 9'd1 - {5'd0, ekw});
    end

    // RAMs
    logic [LADDR_W-1:0] l_waddr, l_raddr;
    logic [15:0] l_rdata, k_rdata;
    logic [RING_W-1:0] ring_rd;
    logic [COL_W-1:0]  col_rd;
    assign ring_rd = r0_reg + ii_reg;
    assign col_rd  = c0_reg + COL_W'(jj_reg);
    assign l_raddr = {ring_rd, col_rd};
    assign l_waddr = {row_c[RING_W-1:0], col_c};

    vconv_ram #(.WIDTH(16), .DEPTH(LSTORE_DEPTH)) u_line_ram (
        .aclk(aclk), .we(pix_acc), .waddr(l_waddr), .wdata(s_value),
        .raddr(l_raddr), .rdata(l_rdata)
    );
    vconv_ram #(.WIDTH(16), .DEPTH(KSTORE_DEPTH)) u_kernel_ram (
        .aclk(aclk), .we(coef_acc), .waddr(kwi_reg), .wdata(s_value),
        .raddr(kidx_reg), .rdata(k_rdata)
    );

    // tap sequencing
    logic last_tap, out_free;
    assign last_tap = ({1'b0, ii_reg} == ekh - 4'd1) && ({1'b0, jj_reg} == ekw - 4'd1);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (pix_acc && emit) state_next = S_RUN;
            S_RUN:  if (last_tap) state_next = S_WAIT;
            S_WAIT: if (!rd_v_reg && !prod_v_reg) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            iw_reg     <= 9'd256;
            ih_reg     <= 16'd256;
            kw_reg     <= 4'd3;
            kh_reg     <= 4'd3;
            row_reg    <= '0;
            col_reg    <= '0;
            kwi_reg    <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_v_reg   <= (state_reg == S_RUN);
            prod_v_reg <= rd_v_reg;
            if (cfg_acc) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   iw_reg <= cfg_data[8:0];
                    REG_IMAGE_HEIGHT:  ih_reg <= cfg_data;
                    REG_KERNEL_WIDTH:  kw_reg <= cfg_data[3:0];
                    REG_KERNEL_HEIGHT: kh_reg <= cfg_data[3:0];
                    default: ;
                endcase
                row_reg <= '0;
                col_reg <= '0;
            end
            if (coef_acc) begin
                kwi_reg <= kwi_reg + KIDX_W'(1);
            end
            if (pix_acc) begin
                kwi_reg <= '0;
                if ({1'b0, col_c} + 9'd1 >= ew) begin
                    col_reg <= '0;
                    row_reg <= ({1'b0, row_c} + 17'd1 >= {1'b0, eh}) ? 16'd0 : row_c + 16'd1;
                end else begin
                    col_reg <= col_c + COL_W'(1);
                    row_reg <= row_c;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // window datapath
    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            r0_reg   <= r0_c[RING_W-1:0];
            c0_reg   <= c0_c;
            ii_reg   <= '0;
            jj_reg   <= '0;
            kidx_reg <= '0;
            acc_reg  <= '0;
            last_reg <= (row_c == eh - 16'd1) && ({1'b0, col_c} == ew - 9'd1);
        end else if (state_reg == S_RUN) begin
            kidx_reg <= kidx_reg + KIDX_W'(1);
            if ({1'b0, jj_reg} == ekw - 4'd1) begin
                jj_reg <= '0;
                ii_reg <= ii_reg + RING_W'(1);
            end else begin
                jj_reg <= jj_reg + RING_W'(1);
            end
        end
        prod_reg <= $signed(l_rdata) * $signed(k_rdata);
        if (prod_v_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
        if (state_reg == S_DONE && out_free) begin
            m_window_sum    <= acc_reg;
            m_last_of_plane <= last_reg;
        end
    end
endmodule
`default_nettype wire

FILE: src/vconv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vconv_checker: port-level checks for the convolution block
// Watches handshakes on the top level's ports.
// ----------------------------------------------------------------------------
module vconv_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);
    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    // output is empty right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result after reset");

    // never a stream request and a register write on the same edge
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && cfg_valid && cfg_ready)) else $error("overlap");
endmodule

bind valid_2d_convolution_top vconv_checker u_vconv_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
`default_nettype wire
